FILE: hdl/smlf_pkg.sv
// Shared types and constants of the star MAC learning forwarder.
`timescale 1ns / 1ps

package smlf_pkg;

  localparam int MAC_W   = 48;
  localparam int NODE_W  = 3;
  localparam int PORT_W  = 3;
  localparam int ENODE_W = 2;
  localparam int MASK_W  = 4;

  localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_W{1'b1}};

  // Depth of the queue between the classifier and the table engine.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Frame header after classification, as it waits in the queue.
  typedef struct packed {
    logic              valid_node;
    logic              is_hub;
    logic              local_in;
    logic              learn;
    logic              lookup;
    logic [NODE_W-1:0] node;
    logic [MASK_W-1:0] flood_mask;
    logic [MAC_W-1:0]  src;
    logic [MAC_W-1:0]  dst;
  } req_t;

  // Forwarding decision for one frame.
  typedef struct packed {
    logic              to_uplink;
    logic              to_local;
    logic [MASK_W-1:0] port_mask;
    logic              learned;
    logic              dst_known;
    logic              table_full;
  } res_t;

endpackage

FILE: hdl/smlf_in_if.sv
// Frame header channel interface.
`timescale 1ns / 1ps

interface smlf_in_if
  import smlf_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [NODE_W-1:0]        node_id;
  logic                     from_local;
  logic signed [PORT_W-1:0] in_port;
  logic [MAC_W-1:0]         src_mac;
  logic [MAC_W-1:0]         dst_mac;

  modport source (output valid, node_id, from_local, in_port, src_mac, dst_mac,
                  input ready);
  modport sink (input valid, node_id, from_local, in_port, src_mac, dst_mac,
                output ready);
endinterface

FILE: hdl/smlf_out_if.sv
// Forwarding decision channel interface.
`timescale 1ns / 1ps

interface smlf_out_if
  import smlf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              to_uplink;
  logic              to_local;
  logic [MASK_W-1:0] port_mask;
  logic              learned;
  logic              dst_known;
  logic              table_full;

  modport source (output valid, to_uplink, to_local, port_mask, learned, dst_known,
                  table_full, input ready);
  modport sink (input valid, to_uplink, to_local, port_mask, learned, dst_known,
                table_full, output ready);
endinterface

FILE: hdl/star_mac_learning_forwarder.sv
// Top level of the star MAC learning forwarder.
//
//   channel  | direction | payload
//   ---------+-----------+--------------------------------------------------------
//   in_ch    | in        | node_id, from_local, in_port, src_mac, dst_mac
//   out_ch   | out       | to_uplink, to_local, port_mask, learned, dst_known,
//            |           | table_full
//
// An item that needs the table is taken from the queue, then each stored entry
// is read in turn through the single read port of the table memory, the last
// entry is compared and the scan closed, and the engine then learns and registers
// the decision. An item that needs neither learning nor lookup, or meets an empty
// table, skips the scan. Reset is synchronous and active low; it empties the
// queue, the table (through its fill count) and the result register, and needs
// no clearing pass. The input side keeps accepting while the queue has room, so a
// stalled result stalls the input only once the two-entry queue is full.
`timescale 1ns / 1ps

module star_mac_learning_forwarder
  import smlf_pkg::*;
#(
  parameter int NUM_SPOKES  = 4,
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  smlf_in_if.sink     in_ch,
  smlf_out_if.source  out_ch
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // Classified requests travel from the front end to the table engine.
  logic             q_push;
  logic             q_full;
  req_t             push_req;
  logic             q_vld;
  req_t             q_req;
  logic             q_pop;
  logic [CNT_W-1:0] fill_cnt;

  // The front end decides whether a frame learns, looks up, and how the hub
  // floods, so the engine only has to search and pick.
  smlf_front #(
    .NUM_SPOKES(NUM_SPOKES)
  ) u_front (
    .in_ch (in_ch),
    .q_full(q_full),
    .q_push(q_push),
    .q_req (push_req)
  );

  smlf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_req(push_req),
    .full    (q_full),
    .q_vld   (q_vld),
    .q_req   (q_req),
    .pop     (q_pop)
  );

  // The engine scans only the filled part of the table; entries are appended
  // in order and never evicted, so the fill count doubles as the valid map.
  smlf_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_vld   (q_vld),
    .q_req   (q_req),
    .q_pop   (q_pop),
    .out_ch  (out_ch),
    .fill_cnt(fill_cnt)
  );

  // The table never holds more entries than it has rows.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_cnt <= CNT_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // Entries are never removed, so the fill count never goes down.
  a_fill_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> fill_cnt >= $past(fill_cnt))
    else $error("fill count decreased");

  // A full-table report is only possible once every row is in use.
  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.table_full) |-> (fill_cnt == CNT_W'(TABLE_DEPTH)))
    else $error("table_full reported with free rows");

  // A known destination needs at least one learned entry.
  a_known_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.dst_known) |-> (fill_cnt != '0))
    else $error("destination known in an empty table");

endmodule

FILE: hdl/smlf_front.sv
// Front end: accepts frame headers and classifies them into queue requests.
`timescale 1ns / 1ps

module smlf_front
  import smlf_pkg::*;
#(
  parameter int NUM_SPOKES = 4
) (
  smlf_in_if.sink in_ch,
  input  logic    q_full,
  output logic    q_push,
  output req_t    q_req
);

  logic              valid_node;
  logic              is_hub;
  logic              local_in;
  logic [MASK_W-1:0] flood;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  assign valid_node = int'(in_ch.node_id) <= NUM_SPOKES;
  assign is_hub     = int'(in_ch.node_id) == NUM_SPOKES;
  // The hub has no local access side.
  assign local_in   = in_ch.from_local && !is_hub;

  // A negative incoming port excludes nothing from the flood.
  always_comb begin
    for (int i = 0; i < MASK_W; i++) begin
      flood[i] = (i < NUM_SPOKES) &&
                 (in_ch.in_port[PORT_W-1] || (in_ch.in_port[1:0] != 2'(i)));
    end
  end

  always_comb begin
    q_req.valid_node = valid_node;
    q_req.is_hub     = is_hub;
    q_req.local_in   = local_in;
    q_req.learn      = valid_node && local_in && (in_ch.src_mac != MAC_BCAST);
    q_req.lookup     = valid_node && (in_ch.dst_mac != MAC_BCAST);
    q_req.node       = in_ch.node_id;
    q_req.flood_mask = flood;
    q_req.src        = in_ch.src_mac;
    q_req.dst        = in_ch.dst_mac;
  end

endmodule

FILE: hdl/smlf_queue.sv
// Short request queue between the classifier and the table engine.
`timescale 1ns / 1ps

module smlf_queue
  import smlf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_req,
  output logic full,
  output logic q_vld,
  output req_t q_req,
  input  logic pop
);

  req_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign q_vld = cnt_r != '0;
  assign q_req = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

FILE: hdl/smlf_back.sv
// Back end: scans the MAC table, learns, decides forwarding, holds the result.
`timescale 1ns / 1ps

module smlf_back
  import smlf_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_vld,
  input  req_t             q_req,
  output logic             q_pop,
  smlf_out_if.source       out_ch,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] fill_cnt
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  typedef struct packed {
    logic [MAC_W-1:0]   mac;
    logic [ENODE_W-1:0] node;
  } tbl_ent_t;

  tbl_ent_t tbl_mem [TABLE_DEPTH];

  logic [1:0]         state_r, state_nxt;
  req_t               cur_r, cur_nxt;
  logic [CNT_W-1:0]   issue_r, issue_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]      rd_idx_r, rd_idx_nxt;
  tbl_ent_t           rd_data_r;
  logic               src_hit_r, src_hit_nxt;
  logic [AW-1:0]      src_idx_r, src_idx_nxt;
  logic               dst_hit_r, dst_hit_nxt;
  logic [ENODE_W-1:0] dst_node_r, dst_node_nxt;
  logic               out_vld_r, out_vld_nxt;
  res_t               out_r, out_nxt;

  logic               issuing;
  logic               fin_go;
  logic               room;
  logic               learn_hit, learn_new, learn_full, learned;
  logic               self_hit, known;
  logic [ENODE_W-1:0] target;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  res_t               res;

  assign fill_cnt = fill_r;
  assign issuing  = (state_r == ST_SCAN) && (issue_r < fill_r);
  assign fin_go   = (state_r == ST_FIN) && (!out_vld_r || out_ch.ready);
  assign q_pop    = (state_r == ST_IDLE) && q_vld;
  assign room     = fill_r < CNT_W'(TABLE_DEPTH);

  // Learning comes first; a destination equal to the source sees the new node.
  always_comb begin
    learn_hit  = cur_r.learn && src_hit_r;
    learn_new  = cur_r.learn && !src_hit_r && room;
    learn_full = cur_r.learn && !src_hit_r && !room;
    learned    = learn_hit || learn_new;
    self_hit   = learned && cur_r.lookup && (cur_r.dst == cur_r.src);
    known      = cur_r.lookup && (self_hit || dst_hit_r);
    target     = self_hit ? cur_r.node[ENODE_W-1:0] : dst_node_r;
    wr_en      = fin_go && learned;
    wr_addr    = learn_hit ? src_idx_r : fill_r[AW-1:0];
  end

  always_comb begin
    res            = '0;
    res.learned    = learned;
    res.dst_known  = known;
    res.table_full = learn_full;
    if (cur_r.valid_node) begin
      if (known) begin
        if (cur_r.is_hub) begin
          res.port_mask = MASK_W'(1) << target;
        end else if ({1'b0, target} == cur_r.node) begin
          res.to_local = !cur_r.local_in;
        end else begin
          res.to_uplink = cur_r.local_in;
        end
      end else if (cur_r.is_hub) begin
        res.port_mask = cur_r.flood_mask;
      end else begin
        res.to_uplink = cur_r.local_in;
        res.to_local  = !cur_r.local_in;
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    issue_nxt    = issue_r;
    fill_nxt     = fill_r;
    rd_vld_nxt   = 1'b0;
    rd_idx_nxt   = issue_r[AW-1:0];
    src_hit_nxt  = src_hit_r;
    src_idx_nxt  = src_idx_r;
    dst_hit_nxt  = dst_hit_r;
    dst_node_nxt = dst_node_r;
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;

    case (state_r)
      ST_IDLE: begin
        if (q_vld) begin
          cur_nxt     = q_req;
          issue_nxt   = '0;
          src_hit_nxt = 1'b0;
          dst_hit_nxt = 1'b0;
          state_nxt   = ((q_req.learn || q_req.lookup) && (fill_r != '0)) ?
                        ST_SCAN : ST_FIN;
        end
      end
      ST_SCAN: begin
        if (issuing) begin
          issue_nxt  = issue_r + 1'b1;
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r) begin
          if (cur_r.learn && (rd_data_r.mac == cur_r.src)) begin
            src_hit_nxt = 1'b1;
            src_idx_nxt = rd_idx_r;
          end
          if (cur_r.lookup && (rd_data_r.mac == cur_r.dst)) begin
            dst_hit_nxt  = 1'b1;
            dst_node_nxt = rd_data_r.node;
          end
        end
        if (!issuing && !rd_vld_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          out_nxt     = res;
          out_vld_nxt = 1'b1;
          fill_nxt    = fill_r + CNT_W'(learn_new);
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fill_r    <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    issue_r    <= issue_nxt;
    rd_idx_r   <= rd_idx_nxt;
    src_hit_r  <= src_hit_nxt;
    src_idx_r  <= src_idx_nxt;
    dst_hit_r  <= dst_hit_nxt;
    dst_node_r <= dst_node_nxt;
    out_r      <= out_nxt;
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= '{mac: cur_r.src, node: cur_r.node[ENODE_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= tbl_mem[issue_r[AW-1:0]];
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.to_uplink  = out_r.to_uplink;
  assign out_ch.to_local   = out_r.to_local;
  assign out_ch.port_mask  = out_r.port_mask;
  assign out_ch.learned    = out_r.learned;
  assign out_ch.dst_known  = out_r.dst_known;
  assign out_ch.table_full = out_r.table_full;

endmodule
